>>> rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles package
// Shared widths, fixed-point constants, the CORDIC arctangent table and the
// work item that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int IN_W    = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  // 2*(a*b + c*d) of two Q14 products, and 1 - 2*(...) in Q28.
  localparam int PROD_W = 34;
  // Clamped pitch sine, +-2^28.
  localparam int SP_W   = 30;
  // Radicand 2^56 - sp^2 and the square root remainder.
  localparam int D_W    = 58;
  // Root bits: the root is at most 2^28.
  localparam int SQ_BITS = 29;
  // CORDIC vector width and angle accumulator width (1/65536 degree).
  localparam int XY_W   = 37;
  localparam int Z_W    = 27;
  // Rounded angle before saturation.
  localparam int R_W    = Z_W - 9;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  localparam logic signed [PROD_W-1:0] ONE_Q28 = PROD_W'(64'sd268435456);
  localparam logic signed [SP_W-1:0]   SP_MAX  = SP_W'(64'sd268435456);
  localparam logic        [D_W-1:0]    ONE_Q56 = D_W'(64'd72057594037927936);
  localparam logic signed [Z_W-1:0]    DEG180  = Z_W'(64'sd11796480);
  localparam logic signed [Z_W-1:0]    Z_HALF  = Z_W'(64'sd256);
  localparam logic signed [R_W-1:0]    OUT_180 = R_W'(64'sd23040);
  localparam logic signed [R_W-1:0]    OUT_90  = R_W'(64'sd11520);
  localparam logic signed [R_W-1:0]    OUT_360 = R_W'(64'sd46080);

  typedef struct packed {
    logic signed [PROD_W-1:0] sr;
    logic signed [PROD_W-1:0] cr;
    logic signed [PROD_W-1:0] sy;
    logic signed [PROD_W-1:0] cy;
    logic signed [SP_W-1:0]   sp;
  } work_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(64'sd2949120);
      1:  v = Z_W'(64'sd1740967);
      2:  v = Z_W'(64'sd919879);
      3:  v = Z_W'(64'sd466945);
      4:  v = Z_W'(64'sd234379);
      5:  v = Z_W'(64'sd117304);
      6:  v = Z_W'(64'sd58666);
      7:  v = Z_W'(64'sd29335);
      8:  v = Z_W'(64'sd14668);
      9:  v = Z_W'(64'sd7334);
      10: v = Z_W'(64'sd3667);
      11: v = Z_W'(64'sd1833);
      12: v = Z_W'(64'sd917);
      13: v = Z_W'(64'sd458);
      14: v = Z_W'(64'sd229);
      15: v = Z_W'(64'sd115);
      16: v = Z_W'(64'sd57);
      17: v = Z_W'(64'sd29);
      18: v = Z_W'(64'sd14);
      19: v = Z_W'(64'sd7);
      20: v = Z_W'(64'sd4);
      21: v = Z_W'(64'sd2);
      22: v = Z_W'(64'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles core
// Converts a Q14 unit quaternion into ZYX roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready) carries one quaternion per
// beat as four signed Q14 components. The result channel (out_valid/
// out_ready) carries one beat per quaternion: roll and pitch signed, yaw in
// [0, 360) degrees, all with 7 fraction bits. Results leave in input order.
// Throughput is one beat per cycle while the receiver keeps out_ready high;
// every stage is a plain register step, so nothing iterates.
// From the edge that accepts an input beat to its result beat the path runs
// through these registers: the accepting edge loads the products, then come
// the sums, the queue entry, one radicand stage, 29 square-root stages (one
// root bit each, this sets most of the depth), the CORDIC pre-stage,
// CORDIC_STAGES rotations and the output register.
// When the receiver stalls, the back end pipeline freezes as a whole, the
// two-entry queue fills and the front end then holds in_ready low.
// Synchronous reset clears every valid flag and the queue; no result is
// presented after reset until a new beat has passed through.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_x,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_y,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_z,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_w,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [q2e_pkg::ROLL_W-1:0]    out_roll_angle,
  output logic signed [q2e_pkg::PITCH_W-1:0]   out_pitch_angle,
  output logic        [q2e_pkg::YAW_W-1:0]     out_yaw_angle
);

  // Front end to queue.
  logic           f_valid, f_ready;
  q2e_pkg::work_t f_work;
  // Queue to back end.
  logic           q_valid, q_ready;
  q2e_pkg::work_t q_work;

  q2e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_quat_x (in_quat_x),
    .in_quat_y (in_quat_y),
    .in_quat_z (in_quat_z),
    .in_quat_w (in_quat_w),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_work  (f_work)
  );

  // The queue lets the front end keep taking beats while the back end is
  // frozen by a stalled receiver.
  q2e_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_work   (f_work),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_work  (q_work)
  );

  q2e_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (q_valid),
    .in_ready        (q_ready),
    .in_work         (q_work),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle)
  );

endmodule

>>> rtl/core/q2e_front.sv
// ----------------------------------------------------------------------------
// Quaternion front end
// Forms the nine component products, then the sine and cosine terms of roll
// and yaw and the pitch sine, clamping the pitch sine to +-1.
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [q2e_pkg::IN_W-1:0]         in_quat_x,
  input  logic signed [q2e_pkg::IN_W-1:0]         in_quat_y,
  input  logic signed [q2e_pkg::IN_W-1:0]         in_quat_z,
  input  logic signed [q2e_pkg::IN_W-1:0]         in_quat_w,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output q2e_pkg::work_t                          out_work
);

  localparam int P_W = 2 * q2e_pkg::IN_W;
  localparam int W   = q2e_pkg::PROD_W;

  logic en;
  logic a_v_r, b_v_r;
  logic signed [P_W-1:0] wx_r, yz_r, wy_r, zx_r, wz_r, xy_r, xx_r, yy_r, zz_r;
  q2e_pkg::work_t b_work_r, work_nxt;
  logic signed [W-1:0] sp_raw;

  assign en       = !b_v_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r     <= in_quat_w * in_quat_x;
      yz_r     <= in_quat_y * in_quat_z;
      wy_r     <= in_quat_w * in_quat_y;
      zx_r     <= in_quat_z * in_quat_x;
      wz_r     <= in_quat_w * in_quat_z;
      xy_r     <= in_quat_x * in_quat_y;
      xx_r     <= in_quat_x * in_quat_x;
      yy_r     <= in_quat_y * in_quat_y;
      zz_r     <= in_quat_z * in_quat_z;
      b_work_r <= work_nxt;
    end
  end

  always_comb begin
    work_nxt.sr = (W'(wx_r) + W'(yz_r)) <<< 1;
    work_nxt.cr = q2e_pkg::ONE_Q28 - ((W'(xx_r) + W'(yy_r)) <<< 1);
    work_nxt.sy = (W'(wz_r) + W'(xy_r)) <<< 1;
    work_nxt.cy = q2e_pkg::ONE_Q28 - ((W'(yy_r) + W'(zz_r)) <<< 1);
    sp_raw      = (W'(wy_r) - W'(zx_r)) <<< 1;
    if (sp_raw > q2e_pkg::ONE_Q28) begin
      work_nxt.sp = q2e_pkg::SP_MAX;
    end else if (sp_raw < -q2e_pkg::ONE_Q28) begin
      work_nxt.sp = -q2e_pkg::SP_MAX;
    end else begin
      work_nxt.sp = sp_raw[q2e_pkg::SP_W-1:0];
    end
  end

  assign out_valid = b_v_r;
  assign out_work  = b_work_r;

endmodule

>>> rtl/core/q2e_fifo.sv
// ----------------------------------------------------------------------------
// Work queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module q2e_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  q2e_pkg::work_t in_work,
  output logic           out_valid,
  input  logic           out_ready,
  output q2e_pkg::work_t out_work
);

  q2e_pkg::work_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           push, pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_work  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_work;
  end

endmodule

>>> rtl/core/q2e_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(y, x) in 1/65536 degree, one stage per rotation, with a front stage
// that folds the left half-plane and catches a zero sine operand.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [q2e_pkg::XY_W-1:0]     y_in,
  input  logic signed [q2e_pkg::XY_W-1:0]     x_in,
  output logic signed [q2e_pkg::Z_W-1:0]      z_out
);

  localparam int XW = q2e_pkg::XY_W;
  localparam int ZW = q2e_pkg::Z_W;

  logic signed [XW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_r [CORDIC_STAGES+1];
  logic                 zf_r [CORDIC_STAGES+1];

  // A zero sine gives 0 or 180 degrees and skips the rotations.
  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (y_in == '0);
      if (y_in == '0) begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= (x_in < 0) ? q2e_pkg::DEG180 : '0;
      end else if (x_in < 0) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= (y_in > 0) ? q2e_pkg::DEG180 : -q2e_pkg::DEG180;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = q2e_pkg::atan_entry(j);
    logic signed [XW-1:0] dx, dy;
    assign dx = x_r[j] >>> j;
    assign dy = y_r[j] >>> j;
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[j+1] <= zf_r[j];
        if (zf_r[j]) begin
          x_r[j+1] <= x_r[j];
          y_r[j+1] <= y_r[j];
          z_r[j+1] <= z_r[j];
        end else if (y_r[j] < 0) begin
          x_r[j+1] <= x_r[j] - dy;
          y_r[j+1] <= y_r[j] + dx;
          z_r[j+1] <= z_r[j] - ANG;
        end else begin
          x_r[j+1] <= x_r[j] + dy;
          y_r[j+1] <= y_r[j] - dx;
          z_r[j+1] <= z_r[j] + ANG;
        end
      end
    end
  end

  assign z_out = z_r[CORDIC_STAGES];

endmodule

>>> rtl/core/q2e_back.sv
// ----------------------------------------------------------------------------
// Angle back end
// Pitch cosine by a bit-per-stage square root, three CORDIC pipelines and the
// final rounding, saturation and yaw wrap into an output register.
// ----------------------------------------------------------------------------
module q2e_back #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  q2e_pkg::work_t                         in_work,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [q2e_pkg::ROLL_W-1:0]      out_roll_angle,
  output logic signed [q2e_pkg::PITCH_W-1:0]     out_pitch_angle,
  output logic        [q2e_pkg::YAW_W-1:0]       out_yaw_angle
);

  localparam int SQ  = q2e_pkg::SQ_BITS;
  localparam int DW  = q2e_pkg::D_W;
  localparam int XW  = q2e_pkg::XY_W;
  localparam int ZW  = q2e_pkg::Z_W;
  localparam int RW  = q2e_pkg::R_W;
  localparam int LAT = 1 + SQ + CORDIC_STAGES + 1 + 1;

  logic           en;
  logic [LAT-1:0] v_r;

  assign en        = !v_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // Radicand stage and the square root pipeline.
  logic [DW-1:0]          rem_r  [SQ+1];
  logic [SQ-1:0]          root_r [SQ+1];
  q2e_pkg::work_t         w_r    [SQ+1];
  logic signed [2*q2e_pkg::SP_W-1:0] sp_sq;

  assign sp_sq = in_work.sp * in_work.sp;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= q2e_pkg::ONE_Q56 - sp_sq[DW-1:0];
      root_r[0] <= '0;
      w_r[0]    <= in_work;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam int B = SQ - 1 - k;
    logic [DW-1:0] trial;
    assign trial = (DW'(root_r[k]) << (B + 1)) + (DW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        w_r[k+1] <= w_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial;
          root_r[k+1] <= root_r[k] | (SQ'(1) << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
      end
    end
  end

  // Three CORDIC pipelines.
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;

  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (XW'(w_r[SQ].sr)),
    .x_in  (XW'(w_r[SQ].cr)),
    .z_out (z_roll)
  );

  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (XW'(w_r[SQ].sp)),
    .x_in  (XW'({1'b0, root_r[SQ]})),
    .z_out (z_pitch)
  );

  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (XW'(w_r[SQ].sy)),
    .x_in  (XW'(w_r[SQ].cy)),
    .z_out (z_yaw)
  );

  // Round to 1/128 degree, ties upwards, then saturate.
  function automatic logic signed [RW-1:0] to_out(input logic signed [ZW-1:0] z,
                                                  input logic signed [RW-1:0] lim);
    logic signed [ZW-1:0] s;
    logic signed [RW-1:0] r;
    s = (z + q2e_pkg::Z_HALF) >>> 9;
    r = s[RW-1:0];
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [RW-1:0] roll_c, pitch_c, yaw_c;

  always_comb begin
    roll_c  = to_out(z_roll, q2e_pkg::OUT_180);
    pitch_c = to_out(z_pitch, q2e_pkg::OUT_90);
    yaw_c   = to_out(z_yaw, q2e_pkg::OUT_180);
    if (yaw_c < 0) yaw_c = yaw_c + q2e_pkg::OUT_360;
    if (yaw_c >= q2e_pkg::OUT_360) yaw_c = yaw_c - q2e_pkg::OUT_360;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_angle  <= roll_c[q2e_pkg::ROLL_W-1:0];
      out_pitch_angle <= pitch_c[q2e_pkg::PITCH_W-1:0];
      out_yaw_angle   <= yaw_c[q2e_pkg::YAW_W-1:0];
    end
  end

endmodule

>>> rtl/core/q2e_checker.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles port checker
// Watches the result channel for idle after reset, stall behaviour and angle ranges.
// ----------------------------------------------------------------------------
module q2e_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [q2e_pkg::ROLL_W-1:0]    out_roll_angle,
  input logic signed [q2e_pkg::PITCH_W-1:0]   out_pitch_angle,
  input logic        [q2e_pkg::YAW_W-1:0]     out_yaw_angle
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat presented straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_roll_angle) && $stable(out_pitch_angle)
      && $stable(out_yaw_angle))
    else $error("result payload changed while stalled");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_yaw_angle < 16'd46080)
    else $error("yaw outside 0 to 360 degrees");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= 15'sd11520 && out_pitch_angle >= -15'sd11520
      && out_roll_angle <= 16'sd23040 && out_roll_angle >= -16'sd23040)
    else $error("roll or pitch beyond its limit");

endmodule

bind quaternion_to_euler_angles_core q2e_checker u_q2e_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_roll_angle  (out_roll_angle),
  .out_pitch_angle (out_pitch_angle),
  .out_yaw_angle   (out_yaw_angle)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles core testbench
// Drives quaternions through the core with bursty input and a stalling
// receiver. A bit-exact integer predictor works out roll, pitch and yaw for
// each accepted beat, and a scoreboard checks the results in order.
// ----------------------------------------------------------------------------
module tb;
  import q2e_pkg::*;

  localparam int STAGES  = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 36;

  typedef struct {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic        [YAW_W-1:0]   yaw;
  } angles_t;

  // Arithmetic shift right on a 64-bit signed value, rounding to minus infinity.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Exact integer square root, bit by bit.
  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC arctangent, result in 1/65536 degree.
  function automatic longint cordic_angle(longint sn, longint cs);
    longint acc, dx, dy;
    acc = 0;
    if (sn == 0) return (cs < 0) ? 64'sd11796480 : 0;
    if (cs < 0) begin
      acc = (sn > 0) ? 64'sd11796480 : -64'sd11796480;
      cs = -cs;
      sn = -sn;
    end
    for (int i = 0; i < STAGES && i < CORDIC_STAGES_MAX; i++) begin
      dx = shr_floor(cs, i);
      dy = shr_floor(sn, i);
      if (sn < 0) begin
        cs -= dy; sn += dx; acc -= longint'(atan_entry(i));
      end else begin
        cs += dy; sn -= dx; acc += longint'(atan_entry(i));
      end
    end
    return acc;
  endfunction

  // Round to 1/128 degree, ties upwards, and saturate.
  function automatic longint round_sat(longint a, longint lim);
    longint r;
    r = shr_floor(a + 256, 9);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(longint qx, longint qy, longint qz, longint qw);
    longint one, sr, cr, sp, sy, cy, cp, yw;
    angles_t a;
    one = 64'sd1 << 28;
    sr = 2 * (qw * qx + qy * qz);
    cr = one - 2 * (qx * qx + qy * qy);
    sp = 2 * (qw * qy - qz * qx);
    sy = 2 * (qw * qz + qx * qy);
    cy = one - 2 * (qy * qy + qz * qz);
    if (sp > one) sp = one;
    if (sp < -one) sp = -one;
    cp = int_sqrt(longint'(one * one) - sp * sp);
    a.roll  = ROLL_W'(round_sat(cordic_angle(sr, cr), 23040));
    a.pitch = PITCH_W'(round_sat(cordic_angle(sp, cp), 11520));
    yw = round_sat(cordic_angle(sy, cy), 23040);
    if (yw < 0) yw += 46080;
    if (yw >= 46080) yw -= 46080;
    a.yaw = YAW_W'(yw);
    return a;
  endfunction

  // Scoreboard: holds the predicted angles in input order.
  class angle_board;
    angles_t pending[$];
    int      mismatches = 0;

    function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
      pending.push_back(euler_of(qx, qy, qz, qw));
    endfunction

    function void check_angles(angles_t got);
      angles_t exp_a;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: roll %0d pitch %0d yaw %0d",
                                       got.roll, got.pitch, got.yaw);
        return;
      end
      exp_a = pending.pop_front();
      if (got.roll !== exp_a.roll || got.pitch !== exp_a.pitch || got.yaw !== exp_a.yaw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Angle mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   exp_a.roll, exp_a.pitch, exp_a.yaw, got.roll, got.pitch, got.yaw);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [IN_W-1:0] in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic signed [ROLL_W-1:0]  out_roll_angle;
  logic signed [PITCH_W-1:0] out_pitch_angle;
  logic        [YAW_W-1:0]   out_yaw_angle;

  angle_board board = new();
  bit         stim_done = 0;

  quaternion_to_euler_angles_core #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Sends one quaternion and waits for its beat to be accepted. The predictor
  // is fed at the accepting edge so the scoreboard sees inputs in order.
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    in_valid  <= 1'b1;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    in_quat_w <= qw;
    do @(posedge clk); while (!in_ready);
    board.note_quat(qx, qy, qz, qw);
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random component; mostly within the unit range, now and then the full
  // 16-bit span so that out-of-range inputs and every bit are exercised.
  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(0, 19) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Builds a roughly normalised quaternion, so that pitch covers its whole
  // range rather than sitting mostly at the clamp.
  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = $signed($urandom_range(0, 2000)) - 1000;
    b = $signed($urandom_range(0, 2000)) - 1000;
    c = $signed($urandom_range(0, 2000)) - 1000;
    d = $signed($urandom_range(0, 2000)) - 1000;
    if ($urandom_range(0, 7) == 0) c = 0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
              16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)));
  endtask

  // Receiver: accepts result beats and stalls in a pattern of its own,
  // alternating stretches of steady ready with stretches of random stalls.
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      phase++;
      if ((phase / 64) % 3 == 0) out_ready <= 1'b1;
      else if ((phase / 64) % 3 == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 9) < 3);
      @(posedge clk);
      if (out_valid && out_ready) begin
        angles_t got;
        got.roll  = out_roll_angle;
        got.pitch = out_pitch_angle;
        got.yaw   = out_yaw_angle;
        board.check_angles(got);
      end
    end
  end

  // Stimulus.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_quat_w = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: identity, the axis rotations, zero sine terms with
    // negative cosine (180 degrees), the all-zero quaternion, gimbal lock at
    // both poles, and the field extremes including out-of-range values.
    send_quat(0, 0, 0, 16384);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, -16384);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(0, 11585, 0, 11585);
    send_quat(0, -11585, 0, 11585);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(0, 0, 11585, -11585);
    send_quat(0, 0, -1, 16384);
    send_quat(1, 0, 0, 16384);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quat(16'sh7fff, 0, 0, 16'sh8000);
    idle_input(1);

    // Hold off until the pipeline has drained completely.
    while (board.pending.size() != 0) @(posedge clk);

    // Random part, in bursts, most of them followed by a random gap.
    for (int sent = 0; sent < 1100; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        else
          send_unit_quat();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // End of run once every expected beat has arrived and a latency has passed.
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
